@@ rtl/spg_pkg.sv @@
package spg_pkg;

    localparam int TIMER_BITS = 16;
    localparam int STEP_BITS  = 15;

    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;
    localparam int IN_DATA_BITS  = 40;
    localparam int OUT_DATA_BITS = 8;

    typedef enum logic [1:0] {
        ACT_TICK = 2'd0,
        ACT_MOVE = 2'd1,
        ACT_HOME = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        PH_NONE = 2'd0,
        PH_SEEK = 2'd1,
        PH_BACK = 2'd2
    } phase_t;

    localparam logic [CFG_IDX_BITS-1:0] CFG_HOME_TRAVEL    = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HOME_PERIOD    = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BACKOFF_STEPS  = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BACKOFF_PERIOD = 2'd3;

    localparam logic [STEP_BITS-1:0]  HOME_TRAVEL_RST    = STEP_BITS'(32000);
    localparam logic [TIMER_BITS-1:0] HOME_PERIOD_RST    = TIMER_BITS'(600);
    localparam logic [STEP_BITS-1:0]  BACKOFF_STEPS_RST  = STEP_BITS'(4000);
    localparam logic [TIMER_BITS-1:0] BACKOFF_PERIOD_RST = TIMER_BITS'(400);
    localparam logic [TIMER_BITS-1:0] COMPARE_RST        = TIMER_BITS'(400);

    typedef struct packed {
        logic [STEP_BITS-1:0]  home_travel;
        logic [TIMER_BITS-1:0] home_period;
        logic [STEP_BITS-1:0]  backoff_steps;
        logic [TIMER_BITS-1:0] backoff_period;
    } spg_cfg_t;

    typedef struct packed {
        action_t               action;
        logic [STEP_BITS-1:0]  distance;
        logic                  direction;
        logic [TIMER_BITS-1:0] period;
        logic                  limit_switch;
    } spg_item_t;

    // step_out lands in bit 0
    typedef struct packed {
        logic       limit_stop;
        logic       move_done;
        logic [1:0] homing_state;
        logic       busy_res;
        logic       dir_out;
        logic       step_out;
    } spg_res_t;

endpackage

@@ rtl/spg_core.sv @@
module spg_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    input  spg_pkg::spg_item_t item,
    input  spg_pkg::spg_cfg_t  cfg,
    output spg_pkg::spg_res_t  res
);
    import spg_pkg::*;

    logic [TIMER_BITS-1:0] tick_count_reg, tick_count_next;
    logic [TIMER_BITS-1:0] compare_reg, compare_next;
    logic [STEP_BITS-1:0]  target_reg, target_next;
    logic [STEP_BITS-1:0]  steps_reg, steps_next;
    logic                  step_level_reg, step_level_next;
    logic                  dir_level_reg, dir_level_next;
    logic                  enabled_reg, enabled_next;
    phase_t                phase_reg, phase_next;
    logic                  done;
    logic                  lstop;
    logic                  match;
    logic [STEP_BITS-1:0]  steps_inc;

    assign match     = (tick_count_reg == compare_reg);
    assign steps_inc = steps_reg + STEP_BITS'(1);

    always_comb
    begin
        tick_count_next = tick_count_reg;
        compare_next    = compare_reg;
        target_next     = target_reg;
        steps_next      = steps_reg;
        step_level_next = step_level_reg;
        dir_level_next  = dir_level_reg;
        enabled_next    = enabled_reg;
        phase_next      = phase_reg;
        done            = 1'b0;
        lstop           = 1'b0;
        case (item.action)
            ACT_TICK:
            begin
                tick_count_next = match ? '0 : tick_count_reg + TIMER_BITS'(1);
                if (match && enabled_reg)
                begin
                    if (!step_level_reg)
                    begin
                        step_level_next = 1'b1;
                    end
                    else
                    begin
                        step_level_next = 1'b0;
                        steps_next      = steps_inc;
                        if (steps_inc >= target_reg)
                        begin
                            phase_next   = PH_NONE;
                            steps_next   = '0;
                            enabled_next = 1'b0;
                            done         = 1'b1;
                        end
                        if (item.limit_switch && phase_next != PH_BACK)
                        begin
                            enabled_next = 1'b0;
                            steps_next   = '0;
                            lstop        = 1'b1;
                            if (phase_next == PH_SEEK)
                            begin
                                // hit while seeking: back off away from switch
                                phase_next     = PH_BACK;
                                dir_level_next = 1'b0;
                                target_next    = cfg.backoff_steps;
                                compare_next   = cfg.backoff_period;
                                enabled_next   = 1'b1;
                            end
                        end
                    end
                end
            end
            ACT_MOVE:
            begin
                dir_level_next = ~item.direction;
                target_next    = item.distance;
                compare_next   = item.period;
                enabled_next   = 1'b1;
            end
            ACT_HOME:
            begin
                phase_next     = PH_SEEK;
                dir_level_next = 1'b1;
                target_next    = cfg.home_travel;
                compare_next   = cfg.home_period;
                enabled_next   = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        res.step_out     = step_level_next;
        res.dir_out      = dir_level_next;
        res.busy_res     = enabled_next;
        res.homing_state = phase_next;
        res.move_done    = done;
        res.limit_stop   = lstop;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg <= '0;
            compare_reg    <= COMPARE_RST;
            target_reg     <= '0;
            steps_reg      <= '0;
            step_level_reg <= 1'b0;
            dir_level_reg  <= 1'b0;
            enabled_reg    <= 1'b0;
            phase_reg      <= PH_NONE;
        end
        else if (item_valid)
        begin
            tick_count_reg <= tick_count_next;
            compare_reg    <= compare_next;
            target_reg     <= target_next;
            steps_reg      <= steps_next;
            step_level_reg <= step_level_next;
            dir_level_reg  <= dir_level_next;
            enabled_reg    <= enabled_next;
            phase_reg      <= phase_next;
        end
    end

endmodule

@@ rtl/stepper_axis_pulse_generator_homing.sv @@
// Channel   | Dir | Accept                      | Contents
// s_axis    | in  | s_axis_tvalid&s_axis_tready | one tick or command
// m_axis    | out | m_axis_tvalid&m_axis_tready | pin levels and status
// cfg       | in  | cfg_valid&cfg_ready         | register index and value
//
// One transaction per clock while s_axis_tready is high.
// Axis state updates in the accept cycle, the result sits in a two-entry
// output buffer (output register plus skid register).
// s_axis_tready drops only while both buffer entries are full.
// cfg_ready is always high. rst_n resets axis state, config and valid flags.
module stepper_axis_pulse_generator_homing (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // distance[14:0], direction[15], period[31:16], limit_switch[32], zero pad
    input  logic [spg_pkg::IN_DATA_BITS-1:0]    s_axis_tdata,
    // action[1:0]
    input  logic [1:0]                          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // step_out[0], dir_out[1], busy_res[2], homing_state[4:3],
    // move_done[5], limit_stop[6], zero pad
    output logic [spg_pkg::OUT_DATA_BITS-1:0]   m_axis_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [spg_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [spg_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
    import spg_pkg::*;

    spg_cfg_t  cfg_reg;
    spg_item_t item;
    spg_res_t  res;
    spg_res_t  out_data_reg;
    spg_res_t  skid_data_reg;
    logic      out_valid_reg;
    logic      skid_valid_reg;
    logic      in_fire;
    logic      m_fire;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = ~skid_valid_reg;
    assign in_fire       = s_axis_tvalid & s_axis_tready;
    assign m_fire        = out_valid_reg & m_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(OUT_DATA_BITS - $bits(spg_res_t))'(0), out_data_reg};

    always_comb
    begin
        item.action       = action_t'(s_axis_tuser);
        item.distance     = s_axis_tdata[STEP_BITS-1:0];
        item.direction    = s_axis_tdata[STEP_BITS];
        item.period       = s_axis_tdata[STEP_BITS+1 +: TIMER_BITS];
        item.limit_switch = s_axis_tdata[STEP_BITS+1+TIMER_BITS];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.home_travel    <= HOME_TRAVEL_RST;
            cfg_reg.home_period    <= HOME_PERIOD_RST;
            cfg_reg.backoff_steps  <= BACKOFF_STEPS_RST;
            cfg_reg.backoff_period <= BACKOFF_PERIOD_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_HOME_TRAVEL:    cfg_reg.home_travel    <= cfg_data[STEP_BITS-1:0];
                CFG_HOME_PERIOD:    cfg_reg.home_period    <= cfg_data[TIMER_BITS-1:0];
                CFG_BACKOFF_STEPS:  cfg_reg.backoff_steps  <= cfg_data[STEP_BITS-1:0];
                CFG_BACKOFF_PERIOD: cfg_reg.backoff_period <= cfg_data[TIMER_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    spg_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (in_fire),
        .item       (item),
        .cfg        (cfg_reg),
        .res        (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (m_fire)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (in_fire)
        begin
            if (out_valid_reg && !m_fire)
            begin
                skid_valid_reg <= 1'b1;
            end
            out_valid_reg <= 1'b1;
        end
        else if (m_fire)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (m_fire)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (in_fire)
        begin
            if (out_valid_reg && !m_fire)
            begin
                skid_data_reg <= res;
            end
            else
            begin
                out_data_reg <= res;
            end
        end
    end

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held without output entry");

    a_accept_gives_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> out_valid_reg)
        else $error("accepted transaction produced no result");

    a_done_stops: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && res.move_done) |-> !res.busy_res)
        else $error("axis still enabled after reaching target");

    a_no_lose: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_axis_tready && !skid_valid_reg && in_fire) |=> skid_valid_reg)
        else $error("result dropped under stall");

endmodule
